>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/kh_pkg.sv
// ---------------------------------------------------------------------------
// kh_pkg
// Types and constants shared by the Keccak-256 byte hasher modules.
// ---------------------------------------------------------------------------
`default_nettype none
package kh_pkg;
    localparam int unsigned LANES = 25;
    localparam logic [8:0] LFSR_POLY = 9'h171;
    localparam logic [7:0] PAD_FIRST = 8'h01;
    localparam logic [7:0] PAD_LAST = 8'h80;

    typedef logic [63:0] t_lane;
    typedef t_lane t_state [LANES];

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERM_FULL,
        ST_PAD,
        ST_PERM_LAST,
        ST_EMIT
    } t_state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;
        logic pad;
        logic round_start;
        logic round_step;
        logic clear;
    } t_cmd;

    // Rotation offsets indexed by x*5+y.
    function automatic logic [5:0] rot_amt(input int unsigned x, input int unsigned y);
        logic [5:0] tbl [25];
        tbl = '{6'd0, 6'd36, 6'd3, 6'd41, 6'd18,
                6'd1, 6'd44, 6'd10, 6'd45, 6'd2,
                6'd62, 6'd6, 6'd43, 6'd15, 6'd61,
                6'd28, 6'd55, 6'd25, 6'd21, 6'd56,
                6'd27, 6'd20, 6'd39, 6'd8, 6'd14};
        return tbl[x*5+y];
    endfunction

    function automatic t_lane rotl(input t_lane v, input logic [5:0] n);
        logic [127:0] d;
        d = {v, v} << n;
        return d[127:64];
    endfunction
endpackage
`default_nettype wire

>>> design/kh_datapath.sv
// ---------------------------------------------------------------------------
// kh_datapath
// Lane store, byte absorber and one Keccak-f round per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module kh_datapath #(
    parameter int unsigned RATE_BYTES = 136
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire kh_pkg::t_cmd i_cmd,
    input  wire logic [7:0]  i_byte,
    input  wire logic [7:0]  i_offset,
    input  wire logic [1:0]  i_word_sel,
    output logic [63:0]      o_word
);
    kh_pkg::t_state r_lane;
    kh_pkg::t_state n_lane;
    kh_pkg::t_state v_round;
    logic [7:0] r_lfsr;
    logic [7:0] n_lfsr;

    // One full round: theta, rho, pi, chi and iota.
    always_comb begin
        kh_pkg::t_lane col [5];
        kh_pkg::t_lane dd [5];
        kh_pkg::t_lane th [25];
        kh_pkg::t_lane tmp [25];
        logic [7:0] l;
        for (int x = 0; x < 5; x++)
            col[x] = r_lane[x] ^ r_lane[x+5] ^ r_lane[x+10] ^ r_lane[x+15] ^ r_lane[x+20];
        for (int x = 0; x < 5; x++)
            dd[x] = col[(x+4)%5] ^ kh_pkg::rotl(col[(x+1)%5], 6'd1);
        for (int i = 0; i < 25; i++)
            th[i] = r_lane[i] ^ dd[i%5];
        for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
                tmp[y + 5*((2*x+3*y)%5)] = kh_pkg::rotl(th[x+5*y],
                    kh_pkg::rot_amt(x, y));
        for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
                v_round[x+5*y] = tmp[x+5*y] ^ (~tmp[(x+1)%5+5*y] & tmp[(x+2)%5+5*y]);
        l = r_lfsr;
        n_lfsr = r_lfsr;
        for (int k = 0; k < 7; k++) begin
            v_round[0][(1 << k) - 1] = v_round[0][(1 << k) - 1] ^ l[0];
            l = (l << 1) ^ (l[7] ? kh_pkg::LFSR_POLY[7:0] : 8'h00);
        end
        n_lfsr = l;
    end

    // Next-state selection for the lane store.
    always_comb begin
        n_lane = r_lane;
        if (i_cmd.clear) begin
            for (int i = 0; i < 25; i++) n_lane[i] = '0;
        end else if (i_cmd.round_step) begin
            n_lane = v_round;
        end else if (i_cmd.absorb || i_cmd.pad) begin
            for (int i = 0; i < 25; i++) begin
                for (int b = 0; b < 8; b++) begin
                    if (i_cmd.absorb && (i_offset == 8'(i*8+b)))
                        n_lane[i][b*8 +: 8] = n_lane[i][b*8 +: 8] ^ i_byte;
                    if (i_cmd.pad && (i_offset == 8'(i*8+b)))
                        n_lane[i][b*8 +: 8] = n_lane[i][b*8 +: 8] ^ kh_pkg::PAD_FIRST;
                    if (i_cmd.pad && (RATE_BYTES - 1 == i*8+b))
                        n_lane[i][b*8 +: 8] = n_lane[i][b*8 +: 8] ^ kh_pkg::PAD_LAST;
                end
            end
        end
    end

    // Lane store and round-constant LFSR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 25; i++) r_lane[i] <= '0;
            r_lfsr <= 8'd1;
        end else begin
            r_lane <= n_lane;
            if (i_cmd.round_start) r_lfsr <= 8'd1;
            else if (i_cmd.round_step) r_lfsr <= n_lfsr;
        end
    end

    assign o_word = r_lane[i_word_sel];
endmodule
`default_nettype wire

>>> design/kh_ctrl.sv
// ---------------------------------------------------------------------------
// kh_ctrl
// Sequencer for absorb, padding, permutation rounds and digest output.
// ---------------------------------------------------------------------------
`default_nettype none
module kh_ctrl #(
    parameter int unsigned RATE_BYTES = 136,
    parameter int unsigned ROUNDS = 24,
    parameter int unsigned WORDS = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic         i_has_byte,
    input  wire logic         i_last,
    output kh_pkg::t_cmd      o_cmd,
    output logic [7:0]        o_offset,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [1:0]        o_word_index,
    output logic              o_last_word,
    output kh_pkg::t_state_e  o_state
);
    kh_pkg::t_state_e r_state, n_state;
    logic [7:0] r_offset, n_offset;
    logic [4:0] r_round, n_round;
    logic [1:0] r_word, n_word;
    logic       r_fin, n_fin;
    logic       acc;

    // A request is taken only while the sequencer waits in idle.
    assign acc = i_valid && (r_state == kh_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kh_pkg::ST_IDLE;
            r_offset <= '0;
            r_round <= '0;
            r_word <= '0;
            r_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            r_offset <= n_offset;
            r_round <= n_round;
            r_word <= n_word;
            r_fin <= n_fin;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_offset = r_offset;
        n_round = r_round;
        n_word = r_word;
        n_fin = r_fin;
        o_cmd = '0;
        o_stall = (r_state != kh_pkg::ST_IDLE);
        o_valid = 1'b0;
        unique case (r_state)
            kh_pkg::ST_IDLE: begin
                if (acc) begin
                    n_fin = i_last;
                    if (i_has_byte) begin
                        o_cmd.absorb = 1'b1;
                        if (r_offset == 8'(RATE_BYTES - 1)) begin
                            n_offset = '0;
                            n_round = '0;
                            o_cmd.round_start = 1'b1;
                            n_state = kh_pkg::ST_PERM_FULL;
                        end else begin
                            n_offset = r_offset + 8'd1;
                            if (i_last) n_state = kh_pkg::ST_PAD;
                        end
                    end else if (i_last) begin
                        n_state = kh_pkg::ST_PAD;
                    end
                end
            end
            kh_pkg::ST_PERM_FULL, kh_pkg::ST_PERM_LAST: begin
                o_cmd.round_step = 1'b1;
                n_round = r_round + 5'd1;
                if (r_round == 5'(ROUNDS - 1)) begin
                    n_round = '0;
                    if (r_state == kh_pkg::ST_PERM_LAST) begin
                        n_word = '0;
                        n_state = kh_pkg::ST_EMIT;
                    end else if (r_fin) begin
                        n_state = kh_pkg::ST_PAD;
                    end else begin
                        n_state = kh_pkg::ST_IDLE;
                    end
                end
            end
            kh_pkg::ST_PAD: begin
                o_cmd.pad = 1'b1;
                o_cmd.round_start = 1'b1;
                n_round = '0;
                n_state = kh_pkg::ST_PERM_LAST;
            end
            kh_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_word = r_word + 2'd1;
                    if (r_word == 2'(WORDS - 1)) begin
                        o_cmd.clear = 1'b1;
                        n_offset = '0;
                        n_fin = 1'b0;
                        n_state = kh_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = kh_pkg::ST_IDLE;
        endcase
    end

    assign o_offset = r_offset;
    assign o_word_index = r_word;
    assign o_last_word = (r_word == 2'(WORDS - 1));
    assign o_state = r_state;
endmodule
`default_nettype wire

>>> design/keccak256_byte_hasher.sv
// ---------------------------------------------------------------------------
// keccak256_byte_hasher
// Keccak-256 (original padding) over a byte stream, digest as 64-bit words.
// ---------------------------------------------------------------------------
// Channel  Direction  Payload
// input    in         i_msg_byte, i_has_byte, i_last
// output   out        o_digest_word, o_word_index, o_last_word
//
// A byte is taken while idle; a full block stalls the input during its rounds,
// one round per cycle through the single round unit.
// A last item adds a pad step, ROUNDS rounds and then the digest words.
// Reset is synchronous, active low, and clears the state at once.
// A stall on the output holds the current digest word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module keccak256_byte_hasher #(
    parameter int unsigned RATE_BYTES = 136,
    parameter int unsigned ROUNDS = 24,
    parameter int unsigned DIGEST_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);
    localparam int unsigned WORDS = ((DIGEST_BYTES + 7) / 8 > 4) ? 4 : (DIGEST_BYTES + 7) / 8;

    kh_pkg::t_cmd     w_cmd;
    logic [7:0]       w_offset;
    logic [63:0]      w_word;
    kh_pkg::t_state_e w_state;
    logic [63:0]      w_mask;

    kh_ctrl #(.RATE_BYTES(RATE_BYTES), .ROUNDS(ROUNDS), .WORDS(WORDS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_has_byte(i_has_byte), .i_last(i_last), .o_cmd(w_cmd),
        .o_offset(w_offset), .o_valid(o_valid), .i_stall(i_stall),
        .o_word_index(o_word_index), .o_last_word(o_last_word), .o_state(w_state)
    );

    kh_datapath #(.RATE_BYTES(RATE_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_byte(i_msg_byte),
        .i_offset(w_offset), .i_word_sel(o_word_index), .o_word(w_word)
    );

    // Bytes beyond the digest length read as zero.
    always_comb begin
        for (int b = 0; b < 8; b++)
            w_mask[b*8 +: 8] = ((32'(o_word_index) * 8 + b) < DIGEST_BYTES) ? 8'hFF : 8'h00;
    end
    assign o_digest_word = w_word & w_mask;

    `CHK_IMPLY(a_valid_emit, i_clk, i_rst_n, o_valid, w_state == kh_pkg::ST_EMIT)
    `CHK_IMPLY(a_no_accept_busy, i_clk, i_rst_n, w_state != kh_pkg::ST_IDLE, o_stall)
    `CHK_NEXT(a_pad_then_perm, i_clk, i_rst_n, w_cmd.pad, w_state == kh_pkg::ST_PERM_LAST)
endmodule
`default_nettype wire

>>> tb/sv/tb_keccak256_byte_hasher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_keccak256_byte_hasher
// Self-checking testbench for the Keccak-256 byte hasher. Messages are fed
// one byte per request. A built-in Keccak-f[1600] predictor works out each
// digest; every returned word is compared against it (or against a stored
// empty-message digest). The run covers directed short messages, random
// messages and the two special lengths around a block boundary. Traffic
// runs under several idle and stall mixes, with one long output hold-off.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_keccak256_byte_hasher;

    localparam int unsigned RATE = 136;
    localparam int unsigned NROUNDS = 24;
    localparam int unsigned NWORDS = 4;
    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_ITEMS = 60;

    // Rotation offsets indexed by x*5+y.
    localparam int ROT_OFS [25] = '{0, 36, 3, 41, 18, 1, 44, 10, 45, 2,
                                    62, 6, 43, 15, 61, 28, 55, 25, 21, 56,
                                    27, 20, 39, 8, 14};
    // Digest of the empty message, as little-endian 64-bit words.
    localparam logic [63:0] EMPTY_DIGEST [4] = '{64'h3c23f7860146d2c5,
        64'hc003c7dcb27d7e92, 64'h3b2782ca53b600e5, 64'h70a4855d04d8fa7b};

    typedef struct {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last_word;
    } digest_word_t;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       known;
    } byte_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_msg_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    keccak256_byte_hasher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_msg_byte(i_msg_byte), .i_has_byte(i_has_byte), .i_last(i_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [63:0]  sponge [25];
    int unsigned  sponge_ofs;
    digest_word_t digest_q [$];

    int unsigned fails = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned msgs_sent = 0;
    int unsigned words_seen = 0;
    logic        hold_armed = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned idle_cnt = 0;

    function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (64 - n)));
    endfunction

    // Keccak-f[1600]; the round-constant LFSR restarts at one each time.
    function automatic void keccak_f();
        logic [63:0] col [5];
        logic [63:0] tmp [25];
        logic [63:0] d;
        logic [7:0]  lfsr;
        lfsr = 8'h01;
        for (int r = 0; r < NROUNDS; r++) begin
            for (int x = 0; x < 5; x++)
                col[x] = sponge[x] ^ sponge[x+5] ^ sponge[x+10] ^ sponge[x+15]
                         ^ sponge[x+20];
            for (int x = 0; x < 5; x++) begin
                d = col[(x+4)%5] ^ rol64(col[(x+1)%5], 1);
                for (int y = 0; y < 5; y++)
                    sponge[x+5*y] ^= d;
            end
            for (int x = 0; x < 5; x++)
                for (int y = 0; y < 5; y++)
                    tmp[y+5*((2*x+3*y)%5)] = rol64(sponge[x+5*y], ROT_OFS[x*5+y]);
            for (int x = 0; x < 5; x++)
                for (int y = 0; y < 5; y++)
                    sponge[x+5*y] = tmp[x+5*y] ^ (~tmp[(x+1)%5+5*y] & tmp[(x+2)%5+5*y]);
            for (int k = 0; k < 7; k++) begin
                sponge[0] ^= 64'(lfsr[0]) << ((1 << k) - 1);
                lfsr = {lfsr[6:0], 1'b0} ^ (lfsr[7] ? kh_pkg::LFSR_POLY[7:0] : 8'h00);
            end
        end
    endfunction

    function automatic void xor_sponge_byte(input int unsigned pos, input logic [7:0] b);
        if ((pos >> 3) < kh_pkg::LANES)
            sponge[pos >> 3] ^= 64'(b) << ((pos & 7) * 8);
    endfunction

    function automatic void clear_sponge();
        foreach (sponge[j]) sponge[j] = '0;
        sponge_ofs = 0;
    endfunction

    // Absorb one accepted request; on a last request queue the digest words.
    function automatic void absorb_request(input logic [7:0] b, input logic h,
                                           input logic l, input logic known);
        digest_word_t dw;
        if (h) begin
            xor_sponge_byte(sponge_ofs, b);
            sponge_ofs++;
            if (sponge_ofs >= RATE) begin
                keccak_f();
                sponge_ofs = 0;
            end
        end
        if (l) begin
            xor_sponge_byte(sponge_ofs, kh_pkg::PAD_FIRST);
            xor_sponge_byte(RATE - 1, kh_pkg::PAD_LAST);
            keccak_f();
            for (int w = 0; w < NWORDS; w++) begin
                dw.word = known ? EMPTY_DIGEST[w] : sponge[w];
                dw.index = 2'(w);
                dw.last_word = (w == NWORDS - 1);
                digest_q.push_back(dw);
            end
            clear_sponge();
        end
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Offer one request, with random idle cycles ahead of it.
    task automatic send_request(input logic [7:0] b, input logic h, input logic l,
                                input logic known);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_msg_byte <= b;
        i_has_byte <= h;
        i_last <= l;
        do @(posedge i_clk); while (o_stall);
        absorb_request(b, h, l, known);
    endtask

    // Send a message of len random bytes, with stray idle requests mixed in.
    task automatic send_message(input int unsigned len, input logic empty_close,
                                inout int unsigned count);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                send_request(8'($urandom), 1'b0, 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_close, 1'b0);
            count++;
        end
        if (empty_close || len == 0) begin
            send_request(8'($urandom), 1'b0, 1'b1, 1'b0);
            count++;
        end
        msgs_sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off when armed.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted digest word with the oldest expected one.
    always @(posedge i_clk) begin
        digest_word_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                report("unexpected digest word", o_digest_word, 64'h0);
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.word)
                    report("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index)
                    report("word_index", 64'(o_word_index), 64'(want.index));
                if (o_last_word !== want.last_word)
                    report("last_word", 64'(o_last_word), 64'(want.last_word));
            end
        end
    end

    // Watchdog: cycles in which no request moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb_keccak256_byte_hasher failed");
            $finish;
        end
    end

    initial begin
        byte_row_t   rows [] = '{
            '{8'h00, 1'b0, 1'b0, 1'b0},  // idle request only
            '{8'h00, 1'b0, 1'b1, 1'b1},  // empty close: hash of empty string
            '{8'hff, 1'b1, 1'b1, 1'b0},
            '{8'h00, 1'b1, 1'b0, 1'b0},
            '{8'h80, 1'b1, 1'b0, 1'b0},
            '{8'h01, 1'b1, 1'b1, 1'b0},
            '{8'h55, 1'b1, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0},  // idle inside a message
            '{8'haa, 1'b1, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b1, 1'b0},  // close with an empty request
            '{8'h00, 1'b1, 1'b1, 1'b0},
            '{8'h00, 1'b0, 1'b1, 1'b1}   // empty close again after reuse
        };
        int unsigned sent;
        int unsigned phase;
        clear_sponge();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, no idling.
        foreach (rows[r])
            send_request(rows[r].data, rows[r].has, rows[r].last, rows[r].known);

        // Block boundary cases: pad bytes meet, and last byte fills the block.
        send_message(RATE - 1, 1'b0, sent);
        send_message(RATE, 1'b0, sent);

        // Random messages over the idling phases.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            phase = sent * 5 / RAND_ITEMS;
            case (phase)
                0: begin gap_pct = 0; stall_pct = 0; end
                1: begin gap_pct = 54; stall_pct = 0; end
                2: begin
                    gap_pct = 0; stall_pct = 54;
                    hold_armed <= 1'b1;
                end
                3: begin gap_pct = 17; stall_pct = 17; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            send_message($urandom_range(12), ($urandom_range(4) == 0), sent);
        end
        i_valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Covered %0d messages and %0d digest words, incl. block boundary cases,",
                 msgs_sent, words_seen);
        $display("under mixed idle/stall phases and one long output hold-off.");
        if (fails == 0)
            $display("tb_keccak256_byte_hasher passed");
        else
            $display("tb_keccak256_byte_hasher failed");
        $finish;
    end
endmodule
`default_nettype wire
